// ===== rtl/gmvn_pkg.sv =====
package gmvn_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int COORD_BITS_DEF   = 20;

  localparam int IDX_BITS = 12;
  localparam int SEG_BITS = 6;
  localparam int OUT_BITS = 16;
  localparam int ST_BITS  = 2;

  // result status codes
  localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [ST_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_BITS-1:0] ST_ZERO  = 2'd2;

  // configuration register indexes
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

endpackage

// ===== rtl/grid_mesh_vertex_normal.sv =====
// Vertex write: no result. Query out of grid: result on done the cycle after start.
// Query in grid: result after a row-major index walk, five memory reads, 24 multiply steps,
// up to 29 normalize shifts, 31 square-root steps and three divides; a zero normal ends
// after the cross product. One item at a time, busy high meanwhile. Each result shows
// for one cycle on done; the receiver cannot stall. Synchronous reset sets both segment
// registers to 1 and idles the sequencer; the memory is not cleared.
module grid_mesh_vertex_normal #(
  parameter int MAX_VERTICES = gmvn_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = gmvn_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 op,
  input  logic [gmvn_pkg::IDX_BITS-1:0]        vertex_index,
  input  logic signed [COORD_BITS-1:0]         pos_x,
  input  logic signed [COORD_BITS-1:0]         pos_y,
  input  logic signed [COORD_BITS-1:0]         pos_z,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [gmvn_pkg::SEG_BITS-1:0]        cfg_data,
  output logic                                 done,
  output logic [gmvn_pkg::IDX_BITS-1:0]        index_echo,
  output logic signed [gmvn_pkg::OUT_BITS-1:0] normal_x,
  output logic signed [gmvn_pkg::OUT_BITS-1:0] normal_y,
  output logic signed [gmvn_pkg::OUT_BITS-1:0] normal_z,
  output logic [gmvn_pkg::ST_BITS-1:0]         status
);
  import gmvn_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int D  = COORD_BITS + 1;
  localparam int MW = 3 * COORD_BITS;
  localparam int XW = 17;
  localparam logic [XW-1:0] MAXV = XW'(MAX_VERTICES);

  typedef enum logic [3:0] {
    S_IDLE, S_ROWS, S_READ, S_CROSS, S_ABS, S_NORM, S_SQ, S_ROOT, S_DSET, S_DIV
  } state_t;

  state_t state;

  // configuration
  logic [SEG_BITS-1:0] cols_seg, rows_seg;
  logic [SEG_BITS-1:0] cs_eff, rs_eff;
  logic [SEG_BITS:0]   w_c;
  logic [13:0]         total_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_seg <= SEG_BITS'(1);
      rows_seg <= SEG_BITS'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_COLS) cols_seg <= cfg_data;
      else                       rows_seg <= cfg_data;
    end
  end

  assign cs_eff  = (cols_seg == '0) ? SEG_BITS'(1) : cols_seg;
  assign rs_eff  = (rows_seg == '0) ? SEG_BITS'(1) : rows_seg;
  assign w_c     = {1'b0, cs_eff} + 1'b1;
  assign total_c = 14'(w_c * ({1'b0, rs_eff} + 1'b1));

  // vertex memory
  logic [MW-1:0] mem [MAX_VERTICES];
  logic [MW-1:0] rdata;
  logic          wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic [XW-1:0] idx_in;

  assign idx_in = XW'(vertex_index);
  assign wr_en  = (state == S_IDLE) && start && !op && (idx_in < MAXV);

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(idx_in)] <= {pos_x, pos_y, pos_z};
    if (rd_en) rdata <= mem[rd_addr];
  end

  // query context
  logic [XW-1:0]       idx_r, rem_r;
  logic [SEG_BITS:0]   w_r;
  logic [SEG_BITS-1:0] row_r;
  logic                hl, hr, hu, hd;
  logic [5:0]          cnt;
  logic                ok_d;

  // neighbor addresses: self, left, up, right, down
  logic [XW-1:0] nb [5];
  always_comb begin
    nb[0] = idx_r;
    nb[1] = idx_r - 1'b1;
    nb[2] = idx_r - XW'(w_r);
    nb[3] = idx_r + 1'b1;
    nb[4] = idx_r + XW'(w_r);
  end

  assign rd_en   = (state == S_READ) && (cnt < 6'd5);
  assign rd_addr = nb[3'(cnt)][AW-1:0];

  logic signed [COORD_BITS-1:0] vx [5], vy [5], vz [5];

  // edge vectors: left, up, right, down
  logic signed [D-1:0] dx [4], dy [4], dz [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dx[i] = D'(vx[i+1]) - D'(vx[0]);
      dy[i] = D'(vy[i+1]) - D'(vy[0]);
      dz[i] = D'(vz[i+1]) - D'(vz[0]);
    end
  end

  // cross product sequencer
  logic [1:0] pair, comp;
  logic       term, cross_end;
  logic       pv, pneg;
  logic [1:0] pc;
  logic signed [2*D-1:0] prod;
  logic [63:0] acc [3];

  logic [1:0] va, vb, ca, cb, c1, c2;
  logic       pen;
  logic signed [D-1:0] opa, opb;

  always_comb begin
    case (pair)
      2'd0:    begin va = 2'd0; vb = 2'd1; pen = hl && hu; end
      2'd1:    begin va = 2'd3; vb = 2'd0; pen = hd && hl; end
      2'd2:    begin va = 2'd1; vb = 2'd2; pen = hu && hr; end
      default: begin va = 2'd2; vb = 2'd3; pen = hr && hd; end
    endcase
    c1 = (comp == 2'd2) ? 2'd0 : comp + 2'd1;
    c2 = (comp == 2'd0) ? 2'd2 : comp - 2'd1;
    ca = term ? c2 : c1;
    cb = term ? c1 : c2;
    case (ca)
      2'd0:    opa = dx[va];
      2'd1:    opa = dy[va];
      default: opa = dz[va];
    endcase
    case (cb)
      2'd0:    opb = dx[vb];
      2'd1:    opb = dy[vb];
      default: opb = dz[vb];
    endcase
  end

  // magnitude and normalize
  logic [63:0] mag [3];
  logic        neg [3];
  logic [63:0] mmax;
  logic [63:0] amag [3];
  logic        aneg [3];
  logic [63:0] amax;

  always_comb begin
    amax = '0;
    for (int i = 0; i < 3; i++) begin
      aneg[i] = acc[i][63];
      amag[i] = aneg[i] ? (64'd0 - acc[i]) : acc[i];
      if (amag[i] > amax) amax = amag[i];
    end
  end

  // sum of squares and square root
  logic [59:0] sq;
  logic [61:0] n2, sn;
  logic [61:0] n2_full;
  logic [30:0] root;
  logic [34:0] rrem, rrem_sh, rtrial;

  assign n2_full = n2 + 62'(sq);
  assign rrem_sh = {rrem[32:0], sn[61:60]};
  assign rtrial  = {2'b00, root, 2'b01};

  // divide
  logic [1:0]  dc;
  logic [45:0] dr, dsh;
  logic [14:0] q;
  logic [14:0] q_next;
  logic [15:0] qs;
  logic [OUT_BITS-1:0] nrm [3];

  assign q_next = (dr >= dsh) ? {q[13:0], 1'b1} : {q[13:0], 1'b0};
  assign qs     = neg[dc] ? (16'd0 - {1'b0, q_next}) : {1'b0, q_next};

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      pv    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && op) begin
            idx_r      <= idx_in;
            rem_r      <= idx_in;
            w_r        <= w_c;
            row_r      <= '0;
            index_echo <= vertex_index;
            if (idx_in >= XW'(total_c) || idx_in >= MAXV) begin
              nrm[0] <= '0; nrm[1] <= '0; nrm[2] <= '0;
              status <= ST_RANGE;
              done   <= 1'b1;
            end else begin
              state <= S_ROWS;
            end
          end
        end

        // walk the index down by rows
        S_ROWS: begin
          if (rem_r >= XW'(w_r)) begin
            rem_r <= rem_r - XW'(w_r);
            row_r <= row_r + 1'b1;
          end else begin
            hl    <= (rem_r != '0);
            hr    <= (rem_r < XW'(cs_eff));
            hu    <= (row_r != '0);
            hd    <= (row_r < rs_eff);
            cnt   <= '0;
            state <= S_READ;
          end
        end

        // issue five reads, capture each in the cycle after
        S_READ: begin
          ok_d <= (cnt < 6'd5) ? (nb[3'(cnt)] < MAXV) : 1'b0;
          if (cnt != '0) begin
            vx[3'(cnt - 1'b1)] <= ok_d ? rdata[MW-1 -: COORD_BITS] : '0;
            vy[3'(cnt - 1'b1)] <= ok_d ? rdata[2*COORD_BITS-1 -: COORD_BITS] : '0;
            vz[3'(cnt - 1'b1)] <= ok_d ? rdata[COORD_BITS-1:0] : '0;
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd5) begin
            pair      <= '0;
            comp      <= '0;
            term      <= 1'b0;
            cross_end <= 1'b0;
            acc[0] <= '0; acc[1] <= '0; acc[2] <= '0;
            state <= S_CROSS;
          end
        end

        // one product a cycle, accumulate the cycle after
        S_CROSS: begin
          pv <= !cross_end;
          if (!cross_end) begin
            if (pen) prod <= opa * opb;
            else     prod <= '0;
            pc   <= comp;
            pneg <= term;
            term <= !term;
            if (term) begin
              if (comp == 2'd2) begin
                comp <= '0;
                if (pair == 2'd3) cross_end <= 1'b1;
                pair <= pair + 1'b1;
              end else begin
                comp <= comp + 1'b1;
              end
            end
          end
          if (pv) begin
            acc[pc] <= pneg ? acc[pc] - 64'(prod) : acc[pc] + 64'(prod);
          end
          if (cross_end && !pv) state <= S_ABS;
        end

        S_ABS: begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= amag[i];
            neg[i] <= aneg[i];
          end
          mmax <= amax;
          if (amax == '0) begin
            nrm[0] <= '0; nrm[1] <= '0; nrm[2] <= '0;
            status <= ST_ZERO;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_NORM;
          end
        end

        // bring the largest magnitude into [2^29, 2^30)
        S_NORM: begin
          if (mmax[63:30] != '0) begin
            mmax <= mmax >> 1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!mmax[29]) begin
            mmax <= mmax << 1;
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            cnt   <= '0;
            n2    <= '0;
            state <= S_SQ;
          end
        end

        S_SQ: begin
          if (cnt < 6'd3) sq <= mag[2'(cnt)][29:0] * mag[2'(cnt)][29:0];
          if (cnt != '0) n2 <= n2_full;
          if (cnt == 6'd3) begin
            sn    <= n2_full;
            root  <= '0;
            rrem  <= '0;
            cnt   <= '0;
            state <= S_ROOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        // one root bit a cycle
        S_ROOT: begin
          sn <= sn << 2;
          if (rrem_sh >= rtrial) begin
            rrem <= rrem_sh - rtrial;
            root <= {root[29:0], 1'b1};
          end else begin
            rrem <= rrem_sh;
            root <= {root[29:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd30) begin
            dc    <= '0;
            state <= S_DSET;
          end
        end

        S_DSET: begin
          dr    <= {2'b00, mag[dc][29:0], 14'd0} + 46'(root >> 1);
          dsh   <= {1'b0, root, 14'd0};
          q     <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end

        // one quotient bit a cycle
        S_DIV: begin
          if (dr >= dsh) dr <= dr - dsh;
          dsh <= dsh >> 1;
          q   <= q_next;
          cnt <= cnt + 1'b1;
          if (cnt == 6'd14) begin
            nrm[dc] <= qs;
            if (dc == 2'd2) begin
              status <= ST_OK;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              dc    <= dc + 1'b1;
              state <= S_DSET;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign normal_x = nrm[0];
  assign normal_y = nrm[1];
  assign normal_z = nrm[2];

endmodule

// ===== dv/grid_mesh_vertex_normal_chk.sv =====
`timescale 1ns / 1ps

module grid_mesh_vertex_normal_chk
  import gmvn_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       op,
  input  logic [IDX_BITS-1:0]        vertex_index,
  input  logic signed [19:0]         pos_x,
  input  logic signed [19:0]         pos_y,
  input  logic signed [19:0]         pos_z,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [SEG_BITS-1:0]        cfg_data,
  input  logic                       done,
  input  logic [IDX_BITS-1:0]        index_echo,
  input  logic signed [OUT_BITS-1:0] normal_x,
  input  logic signed [OUT_BITS-1:0] normal_y,
  input  logic signed [OUT_BITS-1:0] normal_z,
  input  logic [ST_BITS-1:0]         status,
  output int                         errors,
  output int                         pending
);

  localparam logic OP_WRITE = 1'b0;
  localparam int   DEPTH    = 4096;

  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } vec_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]        idx;
    logic signed [OUT_BITS-1:0] nx;
    logic signed [OUT_BITS-1:0] ny;
    logic signed [OUT_BITS-1:0] nz;
    logic [ST_BITS-1:0]         st;
  } normal_t;

  logic signed [19:0] mem_x [DEPTH];
  logic signed [19:0] mem_y [DEPTH];
  logic signed [19:0] mem_z [DEPTH];
  logic [SEG_BITS-1:0] cols_seg, rows_seg;
  normal_t normals_due[$];

  initial errors = 0;
  assign pending = normals_due.size();

  function automatic vec_t fetch(int unsigned i);
    vec_t v;
    v.x = longint'(mem_x[i]);
    v.y = longint'(mem_y[i]);
    v.z = longint'(mem_z[i]);
    return v;
  endfunction

  function automatic vec_t diff(vec_t a, vec_t b);
    vec_t v;
    v.x = a.x - b.x;
    v.y = a.y - b.y;
    v.z = a.z - b.z;
    return v;
  endfunction

  function automatic vec_t cross_add(vec_t s, vec_t a, vec_t b);
    vec_t v;
    v.x = s.x + a.y * b.z - a.z * b.y;
    v.y = s.y + a.z * b.x - a.x * b.z;
    v.z = s.z + a.x * b.y - a.y * b.x;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Sum the neighbor cross products of one vertex and scale to a unit normal
  function automatic normal_t vertex_normal(logic [IDX_BITS-1:0] idx);
    int unsigned cs, rs, w, total, col, row;
    bit hl, hu, hr, hd;
    vec_t p, lf, up, rt, dn, s;
    longint comp [3];
    longint unsigned mag [3];
    longint unsigned m, n2, len, q;
    bit neg [3];
    normal_t r;
    r = '0;
    r.idx = idx;
    cs = (cols_seg == 0) ? 1 : cols_seg;
    rs = (rows_seg == 0) ? 1 : rows_seg;
    w = cs + 1;
    total = w * (rs + 1);
    if (idx >= total) begin
      r.st = ST_RANGE;
      return r;
    end
    col = idx % w;
    row = idx / w;
    hl = col > 0;
    hr = col < cs;
    hu = row > 0;
    hd = row < rs;
    p = fetch(idx);
    lf = hl ? diff(fetch(idx - 1), p) : p;
    rt = hr ? diff(fetch(idx + 1), p) : p;
    up = hu ? diff(fetch(idx - w), p) : p;
    dn = hd ? diff(fetch(idx + w), p) : p;
    s = '0;
    if (hl && hu) s = cross_add(s, lf, up);
    if (hd && hl) s = cross_add(s, dn, lf);
    if (hu && hr) s = cross_add(s, up, rt);
    if (hr && hd) s = cross_add(s, rt, dn);
    comp[0] = s.x;
    comp[1] = s.y;
    comp[2] = s.z;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i] < 0;
      mag[i] = neg[i] ? -comp[i] : comp[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    // bring the largest magnitude into [2^29, 2^30)
    while (m >= (64'd1 << 30)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    n2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = int_sqrt(n2);
    q = (mag[0] * 16384 + len / 2) / len;
    r.nx = neg[0] ? -q[15:0] : q[15:0];
    q = (mag[1] * 16384 + len / 2) / len;
    r.ny = neg[1] ? -q[15:0] : q[15:0];
    q = (mag[2] * 16384 + len / 2) / len;
    r.nz = neg[2] ? -q[15:0] : q[15:0];
    r.st = ST_OK;
    return r;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    normal_t e;
    if (rst) begin
      cols_seg <= 6'd1;
      rows_seg <= 6'd1;
    end else begin
      // track register writes
      if (cfg_we) begin
        if (cfg_index == REG_COLS) cols_seg <= cfg_data;
        else rows_seg <= cfg_data;
      end
      // compare the word on done with the oldest prediction
      if (done) begin
        if (normals_due.size() == 0) begin
          report("unexpected result", -1, index_echo);
        end else begin
          e = normals_due.pop_front();
          if (index_echo !== e.idx) report("index_echo", e.idx, index_echo);
          if (normal_x !== e.nx) report("normal_x", e.nx, normal_x);
          if (normal_y !== e.ny) report("normal_y", e.ny, normal_y);
          if (normal_z !== e.nz) report("normal_z", e.nz, normal_z);
          if (status !== e.st) report("status", e.st, status);
        end
      end
      // take accepted words
      if (start && !busy) begin
        if (op == OP_WRITE) begin
          mem_x[vertex_index] <= pos_x;
          mem_y[vertex_index] <= pos_y;
          mem_z[vertex_index] <= pos_z;
        end else begin
          normals_due.push_back(vertex_normal(vertex_index));
        end
      end
    end
  end

endmodule

// ===== dv/grid_mesh_vertex_normal_tb.sv =====
`timescale 1ns / 1ps

module grid_mesh_vertex_normal_tb;
  import gmvn_pkg::*;

  localparam logic    OP_WRITE = 1'b0;
  localparam logic    OP_QUERY = 1'b1;
  localparam longint  LIMIT    = 2000000;
  localparam int      TARGET   = 1150;

  // position patterns for a grid fill
  localparam int FILL_SMALL = 0;
  localparam int FILL_FULL  = 1;
  localparam int FILL_FLAT  = 2;
  localparam int FILL_PLANE = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic op = OP_WRITE;
  logic [IDX_BITS-1:0] vertex_index = '0;
  logic signed [19:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_COLS;
  logic [SEG_BITS-1:0] cfg_data = '0;
  logic busy, done;
  logic [IDX_BITS-1:0] index_echo;
  logic signed [OUT_BITS-1:0] normal_x, normal_y, normal_z;
  logic [ST_BITS-1:0] status;
  int errors, pending;
  int writes = 0, queries = 0, settings = 0;
  int cur_cols = 1, cur_rows = 1;
  bit no_gaps = 1'b0;
  longint cycles = 0;

  grid_mesh_vertex_normal u_dut (
    .clk, .rst, .start, .busy, .op, .vertex_index, .pos_x, .pos_y, .pos_z,
    .cfg_we, .cfg_index, .cfg_data, .done, .index_echo, .normal_x, .normal_y,
    .normal_z, .status
  );

  grid_mesh_vertex_normal_chk u_chk (
    .clk, .rst, .start, .busy, .op, .vertex_index, .pos_x, .pos_y, .pos_z,
    .cfg_we, .cfg_index, .cfg_data, .done, .index_echo, .normal_x, .normal_y,
    .normal_z, .status, .errors, .pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one word, after a random hold-off unless no_gaps is set, and wait until it is taken
  task automatic issue(logic o, int idx, logic signed [19:0] x, logic signed [19:0] y,
                       logic signed [19:0] z);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    vertex_index <= idx[IDX_BITS-1:0];
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (o == OP_WRITE) writes++;
    else queries++;
  endtask

  task automatic query(int idx);
    issue(OP_QUERY, idx, 20'($urandom), 20'($urandom), 20'($urandom));
  endtask

  // Drain every outstanding normal before touching registers
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_grid(int c, int r);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_COLS;
    cfg_data <= c[SEG_BITS-1:0];
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_data <= r[SEG_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cols = (c == 0) ? 1 : c;
    cur_rows = (r == 0) ? 1 : r;
    settings++;
  endtask

  function automatic logic signed [19:0] small_coord();
    return 20'(int'($urandom_range(0, 128)) - 64);
  endfunction

  // Write one vertex in the given pattern
  task automatic put_vertex(int idx, int fill);
    int col, row;
    col = idx % (cur_cols + 1);
    row = idx / (cur_cols + 1);
    case (fill)
      FILL_SMALL: begin
        issue(OP_WRITE, idx, small_coord(), small_coord(), small_coord());
      end
      FILL_FULL: begin
        issue(OP_WRITE, idx, 20'($urandom), 20'($urandom), 20'($urandom));
      end
      FILL_FLAT: begin
        issue(OP_WRITE, idx, 20'sd1000, -20'sd77, 20'sd5);
      end
      default: begin
        issue(OP_WRITE, idx, 20'(col * 64) + small_coord(), small_coord(),
              20'(row * 64) + small_coord());
      end
    endcase
  endtask

  task automatic fill_grid(int fill);
    for (int i = 0; i < (cur_cols + 1) * (cur_rows + 1); i++) put_vertex(i, fill);
  endtask

  initial begin
    int total, pick, fill, c, r, n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset grid of 2 x 2 with extreme coordinates
    issue(OP_WRITE, 0, -20'sd524288, 20'sd524287, -20'sd524288);
    issue(OP_WRITE, 1, 20'sd524287, -20'sd524288, 20'sd524287);
    issue(OP_WRITE, 2, 20'sd524287, 20'sd524287, -20'sd524288);
    issue(OP_WRITE, 3, -20'sd524288, -20'sd524288, 20'sd524287);
    for (int i = 0; i < 4; i++) query(i);
    query(4);
    query(4095);
    issue(OP_WRITE, 4095, -20'sd1, -20'sd1, -20'sd1);
    // directed: all vertices coincide, so the normal vanishes
    fill_grid(FILL_FLAT);
    query(0);
    query(3);
    // directed: zero in both registers acts as one
    set_grid(0, 0);
    query(3);
    query(4);
    set_grid(2, 2);
    fill_grid(FILL_PLANE);
    query(4);
    query(1);
    query(8);
    query(9);

    // random phases over grid shapes, the extremes among them
    n = 0;
    while (writes + queries < TARGET || n < 6) begin
      case (n)
        0: begin c = 63; r = 1; end
        1: begin c = 1; r = 63; end
        2: begin c = 0; r = 5; end
        default: begin c = $urandom_range(1, 8); r = $urandom_range(1, 8); end
      endcase
      set_grid(c, r);
      fill = (n % 5 == 4) ? FILL_FLAT : $urandom_range(FILL_SMALL, FILL_PLANE);
      if (fill == FILL_FLAT) fill = (n % 5 == 4) ? FILL_FLAT : FILL_PLANE;
      no_gaps = ($urandom_range(0, 3) == 0);
      fill_grid(fill);
      total = (cur_cols + 1) * (cur_rows + 1);
      repeat (60) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) query($urandom_range(0, total - 1));
        else if (pick < 75) query($urandom_range(0, 4095));
        else if (pick < 95) put_vertex($urandom_range(0, total - 1), $urandom_range(0, 3));
        else issue(OP_WRITE, $urandom_range(0, 4095), 20'($urandom), 20'($urandom),
                   20'($urandom));
      end
      n++;
    end

    drain();
    repeat (250) @(posedge clk);
    $display("covered %0d vertex writes and %0d normal queries", writes, queries);
    $display("over %0d grid settings including 0 and 63 segments", settings);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
